// File: rtl/core/knn_classifier_core_defines.svh
// assertion helpers for the knn classifier core
`ifndef KNN_CLASSIFIER_CORE_DEFINES_SVH
`define KNN_CLASSIFIER_CORE_DEFINES_SVH

// same-cycle implication
`define KNN_ASSERT_IMP(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("knn core check failed");

// next-cycle implication
`define KNN_ASSERT_NXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("knn core check failed");

`endif

// File: rtl/core/knn_pkg.sv
package knn_pkg;

   localparam int PORT_ATTRS  = 8;
   localparam int PORT_ATTR_W = 16;
   localparam int LABEL_W     = 8;
   localparam int SKIP_W      = 10;
   localparam int CSR_DATA_W  = 5;
   localparam int CSR_INDEX_W = 1;
   localparam int QBIT_W      = $clog2(LABEL_W);

   localparam logic OP_ADD      = 1'b0;
   localparam logic OP_CLASSIFY = 1'b1;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_K        = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHTED = 1'b1;

   localparam logic [CSR_DATA_W-1:0] K_RESET = 5'd3;

   typedef struct packed {
      logic                                   op;
      logic [PORT_ATTRS-1:0][PORT_ATTR_W-1:0] attr;
      logic [LABEL_W-1:0]                     label;
      logic                                   skip_en;
      logic [SKIP_W-1:0]                      skip_idx;
   } cmd_type;

   typedef struct packed {
      logic [LABEL_W-1:0] label;
      logic               status;
   } rsp_type;

endpackage

// File: rtl/core/knn_fifo.sv
module knn_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rdata
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wp_ff, rp_ff;
   logic [CW-1:0]    cnt_ff;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == CW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slot_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            wp_ff <= (wp_ff == PW'(DEPTH - 1)) ? '0 : wp_ff + PW'(1);
         end
         if (do_pop) begin
            rp_ff <= (rp_ff == PW'(DEPTH - 1)) ? '0 : rp_ff + PW'(1);
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + CW'(1);
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wp_ff] <= wdata;
      end
   end

endmodule

// File: rtl/core/knn_engine.sv
module knn_engine import knn_pkg::*; #(
   parameter int NUM_ATTRS = 8,
   parameter int MAX_TRAIN = 1024,
   parameter int MAX_K     = 16,
   parameter int ATTR_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             cmd_empty,
   output logic                             cmd_pop,
   input  cmd_type                          cmd,
   input  logic                             rsp_full,
   output logic                             rsp_push,
   output rsp_type                          rsp,
   input  logic [CSR_DATA_W-1:0]            cfg_k,
   input  logic                             cfg_weighted,
   output logic [$clog2(MAX_TRAIN+1)-1:0]   train_count
);
   localparam int AW   = (MAX_TRAIN > 1) ? $clog2(MAX_TRAIN) : 1;
   localparam int CW   = $clog2(MAX_TRAIN + 1);
   localparam int EXW  = (CW > SKIP_W) ? CW : SKIP_W;
   localparam int DW   = 2 * ATTR_BITS + 6;
   localparam int RW   = DW / 2;
   localparam int KIW  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
   localparam int KW   = $clog2(MAX_K + 1);
   localparam int KXW  = KW + CSR_DATA_W;
   localparam int TW   = RW + KW;
   localparam int SW   = RW + LABEL_W + KW;
   localparam int XW   = SW + 2;
   localparam int ROWW = NUM_ATTRS * ATTR_BITS + LABEL_W;
   localparam int NP   = (NUM_ATTRS + 1) / 2;
   localparam int DFW  = ATTR_BITS + 1;
   localparam int SQW  = 2 * DFW;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCAN, ST_SEARCH, ST_WLOAD, ST_WSQRT, ST_WACC,
      ST_DSET, ST_DIV, ST_PVOTE, ST_DONE
   } state_type;

   function automatic logic [ATTR_BITS-1:0] to_attr(input logic [PORT_ATTR_W-1:0] p);
      logic [ATTR_BITS+PORT_ATTR_W-1:0] e;
      e = {{ATTR_BITS{1'b0}}, p};
      return e[ATTR_BITS-1:0];
   endfunction

   state_type state_ff;

   logic [ROWW-1:0] mem [MAX_TRAIN];
   logic [ROWW-1:0] rd_ff;
   logic [ROWW-1:0] wrow;
   logic            mem_we;

   logic [CW-1:0]        count_ff, ia_ff;
   logic [ATTR_BITS-1:0] q_ff [NUM_ATTRS];
   logic                 skip_en_ff;
   logic [SKIP_W-1:0]    skip_idx_ff;
   logic [KW-1:0]        kk_ff, nfill_ff, kk_in;
   logic                 wmode_ff;
   logic [KXW-1:0]       kx;

   // distance pipeline
   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   logic [CW-1:0]      i1_ff, i2_ff, i3_ff, i4_ff;
   logic [LABEL_W-1:0] l2_ff, l3_ff, l4_ff;
   logic [SQW-1:0]     sq_ff [2*NP];
   logic [DW-1:0]      ps_ff [NP];
   logic [DW-1:0]      d4_ff, dsum;

   // neighbor slots
   logic [DW-1:0]      nd_ff [MAX_K];
   logic [LABEL_W-1:0] nl_ff [MAX_K];
   logic [KIW-1:0]     far_ff, sj_ff, vi_ff;
   logic [DW-1:0]      fd_ff;

   // vote and weighting
   logic [DW-1:0]          x_ff, r_ff, bit_ff;
   logic [DW:0]            rb;
   logic [SW-1:0]          s_ff;
   logic [TW-1:0]          t_ff;
   logic [XW-1:0]          rem_ff, cand;
   logic [TW:0]            den_ff;
   logic [QBIT_W-1:0]      db_ff;
   logic [LABEL_W-1:0]     qt_ff, best_ff;
   logic [KW-1:0]          bestc_ff, pcnt;
   logic [MAX_K-1:0]       match;
   logic [RW-1:0]          w;
   rsp_type                res_ff;

   logic start, issue, skip_hit, replace, scan_done, vote_last;

   assign train_count = count_ff;
   assign start    = (state_ff == ST_IDLE) && !cmd_empty && !rsp_full;
   assign cmd_pop  = start;
   assign rsp_push = (state_ff == ST_DONE);
   assign rsp      = res_ff;
   assign mem_we   = start && (cmd.op == OP_ADD) && (count_ff < CW'(MAX_TRAIN));

   assign issue     = (state_ff == ST_SCAN) && (ia_ff < count_ff);
   assign skip_hit  = skip_en_ff && (EXW'(ia_ff) == EXW'(skip_idx_ff));
   assign replace   = (state_ff == ST_SCAN) && v4_ff && (d4_ff < fd_ff);
   assign scan_done = (state_ff == ST_SCAN) && !issue &&
                      !(v1_ff || v2_ff || v3_ff || v4_ff);
   assign vote_last = ((KW'(vi_ff) + KW'(1)) == nfill_ff);

   // k of zero acts as one, above the slot count as the slot count
   assign kx = KXW'(cfg_k);
   always_comb begin
      if (kx == '0) begin
         kk_in = KW'(1);
      end else if (kx > KXW'(MAX_K)) begin
         kk_in = KW'(MAX_K);
      end else begin
         kk_in = kx[KW-1:0];
      end
   end

   always_comb begin
      for (int a = 0; a < NUM_ATTRS; a++) begin
         wrow[a*ATTR_BITS +: ATTR_BITS] = to_attr(cmd.attr[a]);
      end
      wrow[ROWW-1 -: LABEL_W] = cmd.label;
   end

   always_comb begin
      dsum = '0;
      for (int h = 0; h < NP; h++) begin
         dsum = dsum + ps_ff[h];
      end
   end

   always_comb begin
      for (int j = 0; j < MAX_K; j++) begin
         match[j] = (KW'(j) < nfill_ff) && (nl_ff[j] == nl_ff[vi_ff]);
      end
      pcnt = KW'($countones(match));
   end

   assign rb   = (DW+1)'(r_ff) + (DW+1)'(bit_ff);
   assign w    = r_ff[RW-1:0];
   assign cand = XW'(den_ff) << db_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[AW-1:0]] <= wrow;
      end
      rd_ff <= mem[ia_ff[AW-1:0]];
   end

   // distance pipeline payload
   always_ff @(posedge clock) begin
      logic signed [DFW-1:0] df;
      logic [DFW-1:0]        mg;
      i1_ff <= ia_ff;
      i2_ff <= i1_ff;
      i3_ff <= i2_ff;
      i4_ff <= i3_ff;
      l2_ff <= rd_ff[ROWW-1 -: LABEL_W];
      l3_ff <= l2_ff;
      l4_ff <= l3_ff;
      for (int a = 0; a < NUM_ATTRS; a++) begin
         df = $signed({rd_ff[a*ATTR_BITS+ATTR_BITS-1], rd_ff[a*ATTR_BITS +: ATTR_BITS]})
            - $signed({q_ff[a][ATTR_BITS-1], q_ff[a]});
         mg = df[DFW-1] ? DFW'(-df) : DFW'(df);
         sq_ff[a] <= SQW'(mg) * SQW'(mg);
      end
      for (int a = NUM_ATTRS; a < 2 * NP; a++) begin
         sq_ff[a] <= '0;
      end
      for (int h = 0; h < NP; h++) begin
         ps_ff[h] <= DW'(sq_ff[2*h]) + DW'(sq_ff[2*h+1]);
      end
      d4_ff <= dsum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         ia_ff    <= '0;
         nfill_ff <= '0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
      end else begin
         v1_ff <= issue && !skip_hit && !replace;
         v2_ff <= v1_ff && !replace;
         v3_ff <= v2_ff && !replace;
         v4_ff <= v3_ff && !replace;
         if (issue && !replace) begin
            ia_ff <= ia_ff + CW'(1);
         end
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  if (cmd.op == OP_ADD) begin
                     res_ff.label <= '0;
                     if (mem_we) begin
                        count_ff      <= count_ff + CW'(1);
                        res_ff.status <= STATUS_OK;
                     end else begin
                        res_ff.status <= STATUS_FULL;
                     end
                     state_ff <= ST_DONE;
                  end else begin
                     for (int a = 0; a < NUM_ATTRS; a++) begin
                        q_ff[a] <= to_attr(cmd.attr[a]);
                     end
                     for (int j = 0; j < MAX_K; j++) begin
                        nd_ff[j] <= '1;
                        nl_ff[j] <= '0;
                     end
                     skip_en_ff  <= cmd.skip_en;
                     skip_idx_ff <= cmd.skip_idx;
                     kk_ff       <= kk_in;
                     wmode_ff    <= cfg_weighted;
                     far_ff      <= '0;
                     fd_ff       <= '1;
                     nfill_ff    <= '0;
                     ia_ff       <= '0;
                     state_ff    <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               if (replace) begin
                  // take the slot, then replay from the next entry after a new search
                  nd_ff[far_ff] <= d4_ff;
                  nl_ff[far_ff] <= l4_ff;
                  if (nfill_ff < kk_ff) begin
                     nfill_ff <= nfill_ff + KW'(1);
                  end
                  ia_ff    <= i4_ff + CW'(1);
                  sj_ff    <= '0;
                  state_ff <= ST_SEARCH;
               end else if (scan_done) begin
                  vi_ff    <= '0;
                  s_ff     <= '0;
                  t_ff     <= '0;
                  bestc_ff <= '0;
                  best_ff  <= '0;
                  if (nfill_ff == '0) begin
                     res_ff.label  <= '0;
                     res_ff.status <= STATUS_OK;
                     state_ff      <= ST_DONE;
                  end else if (wmode_ff) begin
                     state_ff <= ST_WLOAD;
                  end else begin
                     state_ff <= ST_PVOTE;
                  end
               end
            end
            ST_SEARCH: begin
               // first slot holding the largest distance
               if (sj_ff == '0) begin
                  far_ff <= '0;
                  fd_ff  <= nd_ff[0];
               end else if (nd_ff[sj_ff] > fd_ff) begin
                  far_ff <= sj_ff;
                  fd_ff  <= nd_ff[sj_ff];
               end
               if (KW'(sj_ff) == kk_ff - KW'(1)) begin
                  state_ff <= ST_SCAN;
               end else begin
                  sj_ff <= sj_ff + KIW'(1);
               end
            end
            ST_WLOAD: begin
               if (nd_ff[vi_ff] == '0) begin
                  res_ff.label  <= nl_ff[vi_ff];
                  res_ff.status <= STATUS_OK;
                  state_ff      <= ST_DONE;
               end else begin
                  x_ff     <= nd_ff[vi_ff];
                  r_ff     <= '0;
                  bit_ff   <= DW'(1) << (DW - 2);
                  state_ff <= ST_WSQRT;
               end
            end
            ST_WSQRT: begin
               if ((DW+1)'(x_ff) >= rb) begin
                  x_ff <= x_ff - rb[DW-1:0];
                  r_ff <= (r_ff >> 1) + bit_ff;
               end else begin
                  r_ff <= r_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
               if (bit_ff[0]) begin
                  state_ff <= ST_WACC;
               end
            end
            ST_WACC: begin
               s_ff <= s_ff + SW'(w) * SW'(nl_ff[vi_ff]);
               t_ff <= t_ff + TW'(w);
               if (vote_last) begin
                  state_ff <= ST_DSET;
               end else begin
                  vi_ff    <= vi_ff + KIW'(1);
                  state_ff <= ST_WLOAD;
               end
            end
            ST_DSET: begin
               // rounded quotient as (2s + t) / 2t
               rem_ff   <= XW'({s_ff, 1'b0}) + XW'(t_ff);
               den_ff   <= {t_ff, 1'b0};
               db_ff    <= QBIT_W'(LABEL_W - 1);
               qt_ff    <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (rem_ff >= cand) begin
                  rem_ff       <= rem_ff - cand;
                  qt_ff[db_ff] <= 1'b1;
               end
               if (db_ff == '0) begin
                  state_ff <= ST_DONE;
               end else begin
                  db_ff <= db_ff - QBIT_W'(1);
               end
               res_ff.status <= STATUS_OK;
            end
            ST_PVOTE: begin
               if (pcnt > bestc_ff) begin
                  bestc_ff <= pcnt;
                  best_ff  <= nl_ff[vi_ff];
               end
               if (vote_last) begin
                  res_ff.label  <= (pcnt > bestc_ff) ? nl_ff[vi_ff] : best_ff;
                  res_ff.status <= STATUS_OK;
                  state_ff      <= ST_DONE;
               end else begin
                  vi_ff <= vi_ff + KIW'(1);
               end
            end
            ST_DONE: begin
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
         // the division lands its quotient on the way out
         if (state_ff == ST_DIV && db_ff == '0) begin
            res_ff.label <= (rem_ff >= cand) ? (qt_ff | LABEL_W'(1)) : qt_ff;
         end
      end
   end

endmodule

// File: rtl/core/knn_classifier_core.sv
// add: through the command queue, the engine and the response queue, one transaction at a time
// classify: a scan of the stored vectors, one per cycle from the store port but for a replay
//    after each neighbor slot taken and a search of the k slots for the farthest, then a vote
//    over the filled slots (plurality) or a square root per slot and one divide (weighted)
// reset: synchronous, clears queues, store count, k = 3, plurality mode; the store
//    keeps no valid bits and needs no clearing pass
`include "knn_classifier_core_defines.svh"

module knn_classifier_core import knn_pkg::*; #(
   parameter int NUM_ATTRS = 8,
   parameter int MAX_TRAIN = 1024,
   parameter int MAX_K     = 16,
   parameter int ATTR_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic                   req_operation,
   input  logic signed [15:0]     req_attr_0,
   input  logic signed [15:0]     req_attr_1,
   input  logic signed [15:0]     req_attr_2,
   input  logic signed [15:0]     req_attr_3,
   input  logic signed [15:0]     req_attr_4,
   input  logic signed [15:0]     req_attr_5,
   input  logic signed [15:0]     req_attr_6,
   input  logic signed [15:0]     req_attr_7,
   input  logic [LABEL_W-1:0]     req_train_label,
   input  logic                   req_skip_enable,
   input  logic [SKIP_W-1:0]      req_skip_index,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [LABEL_W-1:0]     rsp_result_label,
   output logic                   rsp_status,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);
   localparam int CW = $clog2(MAX_TRAIN + 1);

   cmd_type                cmd_wr, cmd_rd;
   rsp_type                rsp_wr, rsp_rd;
   logic                   cmd_empty, cmd_pop;
   logic                   rsp_full, rsp_push;
   logic [CSR_DATA_W-1:0]  k_ff;
   logic                   weighted_ff;
   logic [CW-1:0]          train_count;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff        <= K_RESET;
         weighted_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_K:        k_ff        <= csr_data;
            CSR_WEIGHTED: weighted_ff <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cmd_wr.op       = req_operation;
      cmd_wr.attr[0]  = req_attr_0;
      cmd_wr.attr[1]  = req_attr_1;
      cmd_wr.attr[2]  = req_attr_2;
      cmd_wr.attr[3]  = req_attr_3;
      cmd_wr.attr[4]  = req_attr_4;
      cmd_wr.attr[5]  = req_attr_5;
      cmd_wr.attr[6]  = req_attr_6;
      cmd_wr.attr[7]  = req_attr_7;
      cmd_wr.label    = req_train_label;
      cmd_wr.skip_en  = req_skip_enable;
      cmd_wr.skip_idx = req_skip_index;
   end

   knn_fifo #(.WIDTH($bits(cmd_type)), .DEPTH(2)) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .full  (req_full),
      .wdata (cmd_wr),
      .pop   (cmd_pop),
      .empty (cmd_empty),
      .rdata (cmd_rd)
   );

   knn_engine #(
      .NUM_ATTRS (NUM_ATTRS),
      .MAX_TRAIN (MAX_TRAIN),
      .MAX_K     (MAX_K),
      .ATTR_BITS (ATTR_BITS)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .cmd_empty    (cmd_empty),
      .cmd_pop      (cmd_pop),
      .cmd          (cmd_rd),
      .rsp_full     (rsp_full),
      .rsp_push     (rsp_push),
      .rsp          (rsp_wr),
      .cfg_k        (k_ff),
      .cfg_weighted (weighted_ff),
      .train_count  (train_count)
   );

   knn_fifo #(.WIDTH($bits(rsp_type)), .DEPTH(2)) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .full  (rsp_full),
      .wdata (rsp_wr),
      .pop   (rsp_pop),
      .empty (rsp_empty),
      .rdata (rsp_rd)
   );

   assign rsp_result_label = rsp_rd.label;
   assign rsp_status       = rsp_rd.status;

   `KNN_ASSERT_IMP(a_cmd_pop_nonempty, clock, reset, cmd_pop, !cmd_empty)
   `KNN_ASSERT_IMP(a_rsp_push_room, clock, reset, rsp_push, !rsp_full)
   `KNN_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, train_count <= CW'(MAX_TRAIN))
   `KNN_ASSERT_NXT(a_push_lands, clock, reset, rsp_push, !rsp_empty)

endmodule
